/* sv/rpt_pkg.sv */
package rpt_pkg;

	localparam int ANGLE_W = 16;
	localparam int ZW = 34;             // residual angle, Q.30 with headroom past pi
	localparam int XW = 33;             // CORDIC x/y, Q.30
	localparam int ANGLE_TO_Q30 = 17;   // Q3.13 -> Q.30
	localparam int ROUND_SHIFT = 30;
	localparam int SPLIT = 16;          // low part of a delta taken into the multipliers

	localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd25736;
	localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [XW-1:0] GAIN_Q30 = 33'sd652032874;

	typedef enum logic [2:0] {
		REG_ANGLE    = 3'd0,
		REG_CENTER_X = 3'd1,
		REG_CENTER_Y = 3'd2,
		REG_SHIFT_X  = 3'd3,
		REG_SHIFT_Y  = 3'd4
	} reg_index_t;

	// atan(2^-i) in Q.30, rounded to nearest
	function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
		logic signed [ZW-1:0] v;
		case (idx)
			5'd0:  v = 34'sd843314857;
			5'd1:  v = 34'sd497837829;
			5'd2:  v = 34'sd263043837;
			5'd3:  v = 34'sd133525159;
			5'd4:  v = 34'sd67021687;
			5'd5:  v = 34'sd33543516;
			5'd6:  v = 34'sd16775851;
			5'd7:  v = 34'sd8388437;
			5'd8:  v = 34'sd4194283;
			5'd9:  v = 34'sd2097149;
			5'd10: v = 34'sd1048576;
			5'd11: v = 34'sd524288;
			5'd12: v = 34'sd262144;
			5'd13: v = 34'sd131072;
			5'd14: v = 34'sd65536;
			5'd15: v = 34'sd32768;
			5'd16: v = 34'sd16384;
			5'd17: v = 34'sd8192;
			5'd18: v = 34'sd4096;
			5'd19: v = 34'sd2048;
			5'd20: v = 34'sd1024;
			5'd21: v = 34'sd512;
			5'd22: v = 34'sd256;
			5'd23: v = 34'sd128;
			5'd24: v = 34'sd64;
			5'd25: v = 34'sd32;
			5'd26: v = 34'sd16;
			5'd27: v = 34'sd8;
			5'd28: v = 34'sd4;
			5'd29: v = 34'sd2;
			5'd30: v = 34'sd1;
			default: v = 34'sd1;
		endcase
		return v;
	endfunction

endpackage

/* sv/rpt_prep.sv */
module rpt_prep import rpt_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic signed [ANGLE_W-1:0]     angle,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	output logic                          valid_s1,
	output logic signed [ZW-1:0]          z_s1,
	output logic                          flip_s1,
	output logic signed [COORD_WIDTH:0]   dx_s1,
	output logic signed [COORD_WIDTH:0]   dy_s1
);

	logic signed [ANGLE_W-1:0] ang_c;
	logic signed [ZW-1:0]      z_raw;
	logic signed [ZW-1:0]      z_next;
	logic                      flip_next;

	always_comb begin
		ang_c = angle;
		if (angle > ANGLE_LIMIT) begin
			ang_c = ANGLE_LIMIT;
		end else if (angle < -ANGLE_LIMIT) begin
			ang_c = -ANGLE_LIMIT;
		end
		z_raw = ZW'(ang_c) <<< ANGLE_TO_Q30;
		// fold into +-pi/2, the half turn is put back by negating cos and sin
		z_next = z_raw;
		flip_next = 1'b0;
		if (z_raw > HALF_PI_Q30) begin
			z_next = z_raw - PI_Q30;
			flip_next = 1'b1;
		end else if (z_raw < -HALF_PI_Q30) begin
			z_next = z_raw + PI_Q30;
			flip_next = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1 <= z_next;
			flip_s1 <= flip_next;
			dx_s1 <= (COORD_WIDTH+1)'(point_x) - (COORD_WIDTH+1)'(center_x);
			dy_s1 <= (COORD_WIDTH+1)'(point_y) - (COORD_WIDTH+1)'(center_y);
		end
	end

endmodule

/* sv/rpt_cordic.sv */
module rpt_cordic import rpt_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid_in,
	input  logic signed [ZW-1:0]        z_in,
	input  logic                        flip_in,
	input  logic signed [COORD_WIDTH:0] dx_in,
	input  logic signed [COORD_WIDTH:0] dy_in,
	output logic                        valid_out,
	output logic signed [XW-1:0]        cos_out,
	output logic signed [XW-1:0]        sin_out,
	output logic                        flip_out,
	output logic signed [COORD_WIDTH:0] dx_out,
	output logic signed [COORD_WIDTH:0] dy_out
);

	logic                        v_s    [CORDIC_STEPS];
	logic signed [XW-1:0]        x_s    [CORDIC_STEPS];
	logic signed [XW-1:0]        y_s    [CORDIC_STEPS];
	logic signed [ZW-1:0]        z_s    [CORDIC_STEPS];
	logic                        flip_s [CORDIC_STEPS];
	logic signed [COORD_WIDTH:0] dx_s   [CORDIC_STEPS];
	logic signed [COORD_WIDTH:0] dy_s   [CORDIC_STEPS];

	// one micro-rotation per stage; the point deltas ride along
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic                        vi;
		logic signed [XW-1:0]        xi;
		logic signed [XW-1:0]        yi;
		logic signed [ZW-1:0]        zi;
		logic                        fi;
		logic signed [COORD_WIDTH:0] dxi;
		logic signed [COORD_WIDTH:0] dyi;

		if (i == 0) begin : g_first
			assign vi = valid_in;
			assign xi = GAIN_Q30;
			assign yi = '0;
			assign zi = z_in;
			assign fi = flip_in;
			assign dxi = dx_in;
			assign dyi = dy_in;
		end else begin : g_next
			assign vi = v_s[i-1];
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
			assign fi = flip_s[i-1];
			assign dxi = dx_s[i-1];
			assign dyi = dy_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!zi[ZW-1]) begin
					x_s[i] <= xi - (yi >>> i);
					y_s[i] <= yi + (xi >>> i);
					z_s[i] <= zi - atan_q30(5'(i));
				end else begin
					x_s[i] <= xi + (yi >>> i);
					y_s[i] <= yi - (xi >>> i);
					z_s[i] <= zi + atan_q30(5'(i));
				end
				flip_s[i] <= fi;
				dx_s[i] <= dxi;
				dy_s[i] <= dyi;
			end
		end
	end

	assign valid_out = v_s[CORDIC_STEPS-1];
	assign cos_out = x_s[CORDIC_STEPS-1];
	assign sin_out = y_s[CORDIC_STEPS-1];
	assign flip_out = flip_s[CORDIC_STEPS-1];
	assign dx_out = dx_s[CORDIC_STEPS-1];
	assign dy_out = dy_s[CORDIC_STEPS-1];

	// residual angle of the last stage is not needed
	logic z_unused;
	assign z_unused = ^z_s[CORDIC_STEPS-1];

endmodule

/* sv/rpt_rotate.sv */
module rpt_rotate import rpt_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_in,
	input  logic signed [XW-1:0]          cos_in,
	input  logic signed [XW-1:0]          sin_in,
	input  logic                          flip_in,
	input  logic signed [COORD_WIDTH:0]   dx_in,
	input  logic signed [COORD_WIDTH:0]   dy_in,
	input  logic signed [COORD_WIDTH:0]   off_x,
	input  logic signed [COORD_WIDTH:0]   off_y,
	output logic                          valid_out,
	output logic signed [COORD_WIDTH-1:0] x_out,
	output logic signed [COORD_WIDTH-1:0] y_out,
	output logic                          sat_out
);

	localparam int DW = COORD_WIDTH + 1;       // delta width
	localparam int HIW = DW - SPLIT;           // high part of a delta
	localparam int PHW = XW + HIW;             // high partial product
	localparam int PLW = XW + SPLIT + 1;       // low partial product
	localparam int PW = COORD_WIDTH + 36;      // full product and sum
	localparam int QW = PW - ROUND_SHIFT;      // after the rounding shift
	localparam int RW = COORD_WIDTH + 7;       // with offset added
	localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) << (ROUND_SHIFT - 1);
	localparam logic signed [RW-1:0] MAX_V = RW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
	localparam logic signed [RW-1:0] MIN_V = ~MAX_V;

	// stage 1: signed cos and sin
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [XW-1:0] cs_s1, sn_s1;
	logic signed [DW-1:0] dx_s1, dy_s1;

	// stage 2: partial products (cdx = cos*dx, sdy = sin*dy, ...)
	logic signed [PHW-1:0] cdx_hi_s2, sdy_hi_s2, sdx_hi_s2, cdy_hi_s2;
	logic signed [PLW-1:0] cdx_lo_s2, sdy_lo_s2, sdx_lo_s2, cdy_lo_s2;

	// stage 3: whole products
	logic signed [PW-1:0] cdx_s3, sdy_s3, sdx_s3, cdy_s3;

	// stage 4: rotated sums with rounding half
	logic signed [PW-1:0] acc_x_s4, acc_y_s4;

	// stage 5: result
	logic signed [COORD_WIDTH-1:0] x_s5, y_s5;
	logic                          sat_s5;

	logic signed [HIW-1:0]   dx_hi, dy_hi;
	logic signed [SPLIT:0]   dx_lo, dy_lo;
	logic signed [QW-1:0]    q_x, q_y;
	logic signed [RW-1:0]    r_x, r_y;
	logic signed [COORD_WIDTH-1:0] c_x, c_y;
	logic                    sat_x, sat_y;

	assign dx_hi = dx_s1[DW-1:SPLIT];
	assign dy_hi = dy_s1[DW-1:SPLIT];
	assign dx_lo = {1'b0, dx_s1[SPLIT-1:0]};
	assign dy_lo = {1'b0, dy_s1[SPLIT-1:0]};

	assign q_x = acc_x_s4[PW-1:ROUND_SHIFT];
	assign q_y = acc_y_s4[PW-1:ROUND_SHIFT];

	always_comb begin
		r_x = RW'(q_x) + RW'(off_x);
		r_y = RW'(q_y) + RW'(off_y);
		sat_x = 1'b1;
		sat_y = 1'b1;
		if (r_x > MAX_V) begin
			c_x = MAX_V[COORD_WIDTH-1:0];
		end else if (r_x < MIN_V) begin
			c_x = MIN_V[COORD_WIDTH-1:0];
		end else begin
			c_x = r_x[COORD_WIDTH-1:0];
			sat_x = 1'b0;
		end
		if (r_y > MAX_V) begin
			c_y = MAX_V[COORD_WIDTH-1:0];
		end else if (r_y < MIN_V) begin
			c_y = MIN_V[COORD_WIDTH-1:0];
		end else begin
			c_y = r_y[COORD_WIDTH-1:0];
			sat_y = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cs_s1 <= flip_in ? -cos_in : cos_in;
			sn_s1 <= flip_in ? -sin_in : sin_in;
			dx_s1 <= dx_in;
			dy_s1 <= dy_in;

			cdx_hi_s2 <= PHW'(cs_s1) * PHW'(dx_hi);
			sdy_hi_s2 <= PHW'(sn_s1) * PHW'(dy_hi);
			sdx_hi_s2 <= PHW'(sn_s1) * PHW'(dx_hi);
			cdy_hi_s2 <= PHW'(cs_s1) * PHW'(dy_hi);
			cdx_lo_s2 <= PLW'(cs_s1) * PLW'(dx_lo);
			sdy_lo_s2 <= PLW'(sn_s1) * PLW'(dy_lo);
			sdx_lo_s2 <= PLW'(sn_s1) * PLW'(dx_lo);
			cdy_lo_s2 <= PLW'(cs_s1) * PLW'(dy_lo);

			cdx_s3 <= (PW'(cdx_hi_s2) <<< SPLIT) + PW'(cdx_lo_s2);
			sdy_s3 <= (PW'(sdy_hi_s2) <<< SPLIT) + PW'(sdy_lo_s2);
			sdx_s3 <= (PW'(sdx_hi_s2) <<< SPLIT) + PW'(sdx_lo_s2);
			cdy_s3 <= (PW'(cdy_hi_s2) <<< SPLIT) + PW'(cdy_lo_s2);

			acc_x_s4 <= cdx_s3 - sdy_s3 + ROUND_HALF;
			acc_y_s4 <= sdx_s3 + cdy_s3 + ROUND_HALF;

			x_s5 <= c_x;
			y_s5 <= c_y;
			sat_s5 <= sat_x | sat_y;
		end
	end

	assign valid_out = v_s5;
	assign x_out = x_s5;
	assign y_out = y_s5;
	assign sat_out = sat_s5;

endmodule

/* sv/rigid_point_transform_2d.sv */
// Rigid 2D point transform: out = R(angle) * (p - center) + center + shift.
// Input channel: in_valid / in_stall with point_x, point_y (signed Q16.16).
// Output channel: out_valid / out_stall with out_x, out_y and saturated.
// A word moves at a rising edge where valid is high and stall is low.
// Configuration: wr_en, wr_index, wr_data; index 0 angle (Q3.13 rad,
// low 16 bits), 1/2 centre x/y, 3/4 shift x/y; other indexes ignored.
// Write registers only while no word is in flight.
// Throughput: one point per cycle while the output does not stall. Registers on
// the way from the edge that accepts the input to out_valid: the angle fold,
// one CORDIC micro-rotation per stage, five stages of split multiply, round
// and clamp, and the output register.
// Reset clears all valid bits and the registers (angle, centre, shift = 0).
// When out_stall holds a result, the next word from the pipeline drops into
// a one-word skid buffer; in_stall rises the cycle after and the pipeline
// freezes until the skid drains. Nothing is lost or repeated.
// Overflowing coordinates clamp to the signed range and raise saturated.
module rigid_point_transform_2d import rpt_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [2:0]                    wr_index,
	input  logic [COORD_WIDTH-1:0]        wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic                          saturated
);

	logic signed [ANGLE_W-1:0]     angle_q;
	logic signed [COORD_WIDTH-1:0] center_x_q, center_y_q, shift_x_q, shift_y_q;
	logic signed [COORD_WIDTH:0]   off_x_q, off_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= '0;
			center_x_q <= '0;
			center_y_q <= '0;
			shift_x_q <= '0;
			shift_y_q <= '0;
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_ANGLE:    angle_q <= wr_data[ANGLE_W-1:0];
				REG_CENTER_X: center_x_q <= wr_data;
				REG_CENTER_Y: center_y_q <= wr_data;
				REG_SHIFT_X:  shift_x_q <= wr_data;
				REG_SHIFT_Y:  shift_y_q <= wr_data;
				default: ;
			endcase
		end
	end

	// centre + shift, registered; used only at the end of the pipe, so the extra register is fine
	always_ff @(posedge clk) begin
		off_x_q <= (COORD_WIDTH+1)'(center_x_q) + (COORD_WIDTH+1)'(shift_x_q);
		off_y_q <= (COORD_WIDTH+1)'(center_y_q) + (COORD_WIDTH+1)'(shift_y_q);
	end

	logic en;
	logic skid_valid_q;
	assign en = ~skid_valid_q;
	assign in_stall = skid_valid_q;

	logic                        pv_s1;
	logic signed [ZW-1:0]        z_s1;
	logic                        flip_s1;
	logic signed [COORD_WIDTH:0] dx_s1, dy_s1;

	rpt_prep #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_prep (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_valid),
		.angle(angle_q),
		.center_x(center_x_q),
		.center_y(center_y_q),
		.point_x(point_x),
		.point_y(point_y),
		.valid_s1(pv_s1),
		.z_s1(z_s1),
		.flip_s1(flip_s1),
		.dx_s1(dx_s1),
		.dy_s1(dy_s1)
	);

	logic                        cv;
	logic signed [XW-1:0]        c_cos, c_sin;
	logic                        c_flip;
	logic signed [COORD_WIDTH:0] c_dx, c_dy;

	rpt_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.COORD_WIDTH(COORD_WIDTH)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_in(pv_s1),
		.z_in(z_s1),
		.flip_in(flip_s1),
		.dx_in(dx_s1),
		.dy_in(dy_s1),
		.valid_out(cv),
		.cos_out(c_cos),
		.sin_out(c_sin),
		.flip_out(c_flip),
		.dx_out(c_dx),
		.dy_out(c_dy)
	);

	logic                          rv;
	logic signed [COORD_WIDTH-1:0] r_x, r_y;
	logic                          r_sat;

	rpt_rotate #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_rotate (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid_in(cv),
		.cos_in(c_cos),
		.sin_in(c_sin),
		.flip_in(c_flip),
		.dx_in(c_dx),
		.dy_in(c_dy),
		.off_x(off_x_q),
		.off_y(off_y_q),
		.valid_out(rv),
		.x_out(r_x),
		.y_out(r_y),
		.sat_out(r_sat)
	);

	logic                          out_valid_q;
	logic signed [COORD_WIDTH-1:0] out_x_q, out_y_q, skid_x_q, skid_y_q;
	logic                          out_sat_q, skid_sat_q;
	logic                          out_free;

	assign out_free = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= skid_valid_q | rv;
			end
			if (skid_valid_q) begin
				if (!out_stall) begin
					skid_valid_q <= 1'b0;
				end
			end else if (rv && !out_free) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_x_q <= skid_x_q;
				out_y_q <= skid_y_q;
				out_sat_q <= skid_sat_q;
			end else begin
				out_x_q <= r_x;
				out_y_q <= r_y;
				out_sat_q <= r_sat;
			end
		end
		if (!skid_valid_q && !out_free) begin
			skid_x_q <= r_x;
			skid_y_q <= r_y;
			skid_sat_q <= r_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign saturated = out_sat_q;

endmodule

/* test/tb_rigid_point_transform_2d.sv */
`timescale 1ns / 100ps

module tb_rigid_point_transform_2d;
	import rpt_pkg::*;

	localparam int STEPS = 16;
	localparam int COORD_W = 32;

	localparam longint ANGLE_MAX = 25736;
	localparam longint ANGLE_SCALE = 131072;          // Q3.13 -> Q.30
	localparam longint HALF_TURN = 64'sd3373259426;   // pi in Q.30
	localparam longint QUARTER_TURN = 64'sd1686629713;
	localparam longint CORDIC_START = 64'sd652032874;
	localparam longint ATAN_ONE = 64'sd843314857;     // atan(1) in Q.30

	localparam logic [2:0] FIRST_UNUSED_REG = 3'd5;
	localparam logic [2:0] LAST_UNUSED_REG = 3'd7;

	localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] C_MIN = 32'sh8000_0000;

	localparam int NUM_ROWS = 34;
	localparam int NUM_PHASES = 6;
	localparam int PHASE_POINTS = 80;
	localparam int HOLD_AT = 115;
	localparam int HOLD_CYCLES = 150;
	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               sat;
	} point_result_t;

	localparam point_result_t NO_RESULT = '0;

	typedef enum bit {ROW_POINT, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t     kind;
		logic [2:0]    idx;
		logic [31:0]   a;
		logic [31:0]   b;
		bit            typed;
		point_result_t want;
	} step_row_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [2:0] wr_index;
	logic [COORD_W-1:0] wr_data;
	logic in_valid;
	logic in_stall;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic out_valid;
	logic out_stall;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic saturated;

	rigid_point_transform_2d #(
		.CORDIC_STEPS(STEPS),
		.COORD_WIDTH(COORD_W)
	) dut (.*);

	// local copy of the register file
	logic [15:0] cfg_angle;
	logic signed [31:0] cfg_cx, cfg_cy, cfg_sx, cfg_sy;

	longint atan_tab [STEPS];
	point_result_t pending_transforms [$];
	int mismatch_count;
	int send_idle_pct, recv_idle_pct;

	step_row_t directed_rows [NUM_ROWS] = '{
		'{ROW_POINT, REG_ANGLE, 32'h0, 32'h0, 1'b1, '{32'sh0, 32'sh0, 1'b0}},
		'{ROW_POINT, REG_ANGLE, C_MAX, C_MAX, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_ANGLE, C_MIN, C_MIN, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_ANGLE, C_MAX, C_MIN, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_ANGLE, 32'h0001_8000, 32'hFFFE_8000, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_SHIFT_X, C_MAX, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_SHIFT_Y, C_MIN, 32'h0, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_ANGLE, 32'h0, 32'h0, 1'b1, '{C_MAX, C_MIN, 1'b0}},
		'{ROW_POINT, REG_ANGLE, C_MAX, C_MIN, 1'b1, '{C_MAX, C_MIN, 1'b1}},
		'{ROW_POINT, REG_ANGLE, C_MIN, C_MAX, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_SHIFT_X, 32'h0, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_SHIFT_Y, 32'h0, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_ANGLE, 32'h0000_7FFF, 32'h0, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_ANGLE, 32'h0001_0000, 32'h0, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_ANGLE, 32'h0, 32'h0001_0000, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_ANGLE, 32'h0000_8000, 32'h0, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_ANGLE, 32'h0001_0000, 32'h0002_0000, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_ANGLE, 32'h0000_6488, 32'h0, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_ANGLE, C_MAX, C_MAX, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_ANGLE, 32'hFFFF_9B78, 32'h0, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_ANGLE, 32'hFFFF_8000, 32'h0000_7FFF, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_ANGLE, 32'h0000_3244, 32'h0, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_ANGLE, 32'h0010_0000, 32'hFFF0_0000, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_ANGLE, 32'h0000_3243, 32'h0, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_ANGLE, 32'h0010_0000, 32'hFFF0_0000, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_ANGLE, 32'hFFFF_CDBC, 32'h0, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_ANGLE, 32'h0010_0000, 32'hFFF0_0000, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_ANGLE, 32'h5A5A_0C00, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_CENTER_X, C_MAX, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, REG_CENTER_Y, C_MIN, 32'h0, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_ANGLE, C_MIN, C_MAX, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_ANGLE, 32'h0, 32'h0, 1'b0, NO_RESULT},
		'{ROW_WRITE, LAST_UNUSED_REG, 32'hA5A5_5A5A, 32'h0, 1'b0, NO_RESULT},
		'{ROW_POINT, REG_ANGLE, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, NO_RESULT}
	};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// atan(2^-i) in Q.30 from the alternating series in Q.62
	function automatic void build_atan_table();
		longint sum;
		longint unsigned term;
		int i, k;
		atan_tab[0] = ATAN_ONE;
		for (i = 1; i < STEPS; i++) begin
			sum = 0;
			for (k = 0; i * (2 * k + 1) <= 62; k++) begin
				term = (64'd1 << (62 - i * (2 * k + 1))) / (2 * k + 1);
				if (k % 2) sum -= longint'(term);
				else sum += longint'(term);
			end
			atan_tab[i] = longint'(($unsigned(sum) + 64'd2147483648) >> 32);
		end
	endfunction

	// floor((a*dx + b*dy + 2^29) / 2^30), exact
	function automatic longint round_rotate(input longint a, b, dx, dy);
		logic signed [95:0] wa, wb, wdx, wdy, acc;
		wa = a;
		wb = b;
		wdx = dx;
		wdy = dy;
		acc = wa * wdx + wb * wdy + (96'sd1 <<< 29);
		return longint'(acc >>> 30);
	endfunction

	function automatic logic signed [31:0] clamp_coord(input longint v, inout logic hit);
		if (v > longint'(C_MAX)) begin
			hit = 1'b1;
			return C_MAX;
		end
		if (v < longint'(C_MIN)) begin
			hit = 1'b1;
			return C_MIN;
		end
		return v[31:0];
	endfunction

	function automatic point_result_t transform_point(input logic signed [31:0] px, py);
		longint ang, z, c, s, step_c, step_s, cx, cy, dx, dy, rx, ry;
		bit flip;
		int i;
		point_result_t r;
		ang = longint'($signed(cfg_angle));
		if (ang > ANGLE_MAX) ang = ANGLE_MAX;
		else if (ang < -ANGLE_MAX) ang = -ANGLE_MAX;
		z = ang * ANGLE_SCALE;
		flip = 1'b0;
		// fold into [-pi/2, pi/2]; sin and cos change sign
		if (z > QUARTER_TURN) begin
			z -= HALF_TURN;
			flip = 1'b1;
		end else if (z < -QUARTER_TURN) begin
			z += HALF_TURN;
			flip = 1'b1;
		end
		c = CORDIC_START;
		s = 0;
		for (i = 0; i < STEPS; i++) begin
			step_c = c >>> i;
			step_s = s >>> i;
			if (z >= 0) begin
				c -= step_s;
				s += step_c;
				z -= atan_tab[i];
			end else begin
				c += step_s;
				s -= step_c;
				z += atan_tab[i];
			end
		end
		if (flip) begin
			c = -c;
			s = -s;
		end
		cx = longint'(cfg_cx);
		cy = longint'(cfg_cy);
		dx = longint'(px) - cx;
		dy = longint'(py) - cy;
		rx = round_rotate(c, -s, dx, dy) + cx + longint'(cfg_sx);
		ry = round_rotate(s, c, dx, dy) + cy + longint'(cfg_sy);
		r.sat = 1'b0;
		r.x = clamp_coord(rx, r.sat);
		r.y = clamp_coord(ry, r.sat);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got, want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		case (idx)
			REG_ANGLE:    cfg_angle = data[15:0];
			REG_CENTER_X: cfg_cx = data;
			REG_CENTER_Y: cfg_cy = data;
			REG_SHIFT_X:  cfg_sx = data;
			REG_SHIFT_Y:  cfg_sy = data;
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// caller drives the next word or lowers in_valid in the step this returns
	task automatic send_point(input logic signed [31:0] px, py, input bit typed,
			input point_result_t want);
		point_result_t exp_word;
		exp_word = typed ? want : transform_point(px, py);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_transforms.push_back(exp_word);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_transforms.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] random_coord();
		case ($urandom_range(3))
			0: return $urandom;
			default: return $signed($urandom) >>> $urandom_range(20, 4);
		endcase
	endfunction

	function automatic logic [31:0] random_offset();
		case ($urandom_range(3))
			0: return '0;
			1: return $urandom;
			default: return random_coord();
		endcase
	endfunction

	task automatic randomize_settings();
		logic [31:0] ang;
		int a;
		case ($urandom_range(5))
			0: ang = $urandom;          // junk in the top half, any angle code
			1: ang = 32'(ANGLE_MAX);
			2: ang = 32'(-ANGLE_MAX);
			default: begin
				a = int'($urandom_range(2 * ANGLE_MAX)) - int'(ANGLE_MAX);
				ang = a;
			end
		endcase
		write_reg(REG_ANGLE, ang);
		write_reg(REG_CENTER_X, random_offset());
		write_reg(REG_CENTER_Y, random_offset());
		write_reg(REG_SHIFT_X, random_offset());
		write_reg(REG_SHIFT_Y, random_offset());
		if ($urandom_range(1))
			write_reg(3'($urandom_range(LAST_UNUSED_REG, FIRST_UNUSED_REG)), $urandom);
	endtask

	// output side: checks each word and drives out_stall
	initial begin
		point_result_t want;
		int words_out, hold_left;
		words_out = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				words_out++;
				if (pending_transforms.size() == 0) begin
					report_mismatch("unexpected word, out_x", out_x, '0);
				end else begin
					want = pending_transforms.pop_front();
					if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
					if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
					if (saturated !== want.sat)
						report_mismatch("saturated", 32'(saturated), 32'(want.sat));
				end
				// long hold-off so the pipe backs up into in_stall
				if (words_out == HOLD_AT) hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
			else quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		int r, phase, n;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_valid = 1'b0;
		point_x = '0;
		point_y = '0;
		out_stall = 1'b0;
		cfg_angle = '0;
		cfg_cx = '0;
		cfg_cy = '0;
		cfg_sx = '0;
		cfg_sy = '0;
		mismatch_count = 0;
		send_idle_pct = 11;
		recv_idle_pct = 45;
		build_atan_table();
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		for (r = 0; r < NUM_ROWS; r++) begin
			if (directed_rows[r].kind == ROW_WRITE) begin
				settle();
				write_reg(directed_rows[r].idx, directed_rows[r].a);
			end else begin
				send_point(directed_rows[r].a, directed_rows[r].b, directed_rows[r].typed,
					directed_rows[r].want);
			end
		end

		for (phase = 0; phase < NUM_PHASES; phase++) begin
			settle();
			if (phase == 2) begin
				send_idle_pct = 45;
				recv_idle_pct = 11;
			end else if (phase == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			randomize_settings();
			for (n = 0; n < PHASE_POINTS; n++)
				send_point(random_coord(), random_coord(), 1'b0, NO_RESULT);
		end

		settle();
		// catch any stray word after the last expected one
		repeat (STEPS + 12) @(posedge clk);
		if (mismatch_count == 0 && pending_transforms.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
